// File: rtl/rtmu_pkg.sv
// ----------------------------------------------------------------------------
// rtmu_pkg
// Shared types and constants for the route table metric update unit.
// ----------------------------------------------------------------------------
package rtmu_pkg;

  localparam logic [15:0] EMPTY_ADDR      = 16'hffff;
  localparam logic [15:0] THRESHOLD_RESET = 16'd3000;

  // item kind carried on in_tuser
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_RAISED    = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_UNCHANGED = 3'd3,
    ST_INSERTED  = 3'd4,
    ST_FULL      = 3'd5,
    ST_LOOKUP    = 3'd6
  } status_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] dest_addr;
    logic [15:0] source_addr;
    logic [15:0] battery_level;
    logic [15:0] signal_strength;
  } rtmu_req_t;

  typedef struct packed {
    status_t     status;
    logic        hit;
    logic [15:0] next_hop;
  } rtmu_rsp_t;

endpackage

// File: rtl/route_table_metric_update_unit.sv
// ----------------------------------------------------------------------------
// route_table_metric_update_unit
// Small routing table updated by route replies and queried by lookups.
// ----------------------------------------------------------------------------
//  channel  | ports                      | contents
//  ---------+----------------------------+----------------------------------
//  input    | in_tvalid/in_tready        | tuser: cmd; tdata: dest, src,
//           | in_tdata[63:0], in_tuser   |   battery, rssi
//  result   | out_tvalid/out_tready      | tuser: status, hit; tdata: hop
//  config   | cfg_wr_en, cfg_wr_data     | battery threshold
//
// One item per cycle while the result is not stalled; an item that is taken
// passes the input register, then the result register, before it can leave.
// The table write and the result register load happen at the same edge, so
// the next item sees the update.
// A stalled result holds the result register and, behind it, the input one.
// Reset (synchronous, rst_n low) empties the table and sets threshold 3000.
// ----------------------------------------------------------------------------
module route_table_metric_update_unit
  import rtmu_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // dest_addr, source_addr, battery_level, signal_strength
  input  logic [0:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // next_hop
  output logic [3:0]  out_tuser,  // status[2:0], hit
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic        s1_v_r;
  rtmu_req_t   s1_req_r;
  logic        out_v_r;
  rtmu_rsp_t   out_rsp_r;
  logic [15:0] thresh_r;
  rtmu_rsp_t   rsp;
  logic        adv;
  logic        s1_take;

  assign adv       = !out_v_r || out_tready;
  assign s1_take   = s1_v_r && adv;
  assign in_tready = !s1_v_r || adv;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r <= '{cmd:             in_tuser[0],
                    dest_addr:       in_tdata[15:0],
                    source_addr:     in_tdata[31:16],
                    battery_level:   in_tdata[47:32],
                    signal_strength: in_tdata[63:48]};
    end
  end

  rtmu_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_take),
    .req       (s1_req_r),
    .threshold (thresh_r),
    .rsp       (rsp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_rsp_r.next_hop;
  assign out_tuser  = {out_rsp_r.hit, out_rsp_r.status};

endmodule

// File: rtl/rtmu_table.sv
// ----------------------------------------------------------------------------
// rtmu_table
// Route table storage plus the single-pass match, decide and write logic.
// The response is combinational from the registered request and the table.
// ----------------------------------------------------------------------------
module rtmu_table
  import rtmu_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  rtmu_req_t   req,
  input  logic [15:0] threshold,
  output rtmu_rsp_t   rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [15:0] dest_r [TABLE_ENTRIES];
  logic [15:0] hop_r  [TABLE_ENTRIES];
  logic [15:0] batt_r [TABLE_ENTRIES];
  logic [15:0] rssi_r [TABLE_ENTRIES];

  logic             m_found;
  logic [IDX_W-1:0] m_idx;
  logic             f_found;
  logic [IDX_W-1:0] f_idx;
  logic [15:0]      m_hop;
  logic [15:0]      m_batt;
  logic [15:0]      m_rssi;

  logic             wr_en;
  logic             wr_dest;
  logic             wr_hop;
  logic [IDX_W-1:0] wr_idx;

  // lowest matching entry and lowest free entry
  always_comb begin
    m_found = 1'b0;
    m_idx   = '0;
    f_found = 1'b0;
    f_idx   = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (!m_found && (req.dest_addr != EMPTY_ADDR) && (dest_r[k] == req.dest_addr)) begin
        m_found = 1'b1;
        m_idx   = IDX_W'(k);
      end
      if (!f_found && (dest_r[k] == EMPTY_ADDR)) begin
        f_found = 1'b1;
        f_idx   = IDX_W'(k);
      end
    end
  end

  assign m_hop  = hop_r[m_idx];
  assign m_batt = batt_r[m_idx];
  assign m_rssi = rssi_r[m_idx];

  // decision
  always_comb begin
    rsp      = '{status: ST_UNCHANGED, hit: 1'b0, next_hop: EMPTY_ADDR};
    wr_en    = 1'b0;
    wr_dest  = 1'b0;
    wr_hop   = 1'b0;
    wr_idx   = m_idx;
    priority if (req.cmd == CMD_LOOKUP) begin
      rsp.status = ST_LOOKUP;
      if (m_found) begin
        rsp.hit      = 1'b1;
        rsp.next_hop = m_hop;
      end
    end else if (req.dest_addr == EMPTY_ADDR) begin
      rsp.status = ST_UNCHANGED;
    end else if (m_found) begin
      rsp.hit      = 1'b1;
      rsp.next_hop = m_hop;
      priority if (m_hop == req.source_addr) begin
        rsp.status = ST_REFRESHED;
        wr_en      = 1'b1;
      end else if (req.battery_level > threshold) begin
        priority if (req.signal_strength > m_rssi) begin
          rsp.status = ST_RAISED;
          wr_en      = 1'b1;
        end else if (req.battery_level > m_batt) begin
          rsp.status   = ST_REPLACED;
          rsp.next_hop = req.source_addr;
          wr_en        = 1'b1;
          wr_hop       = 1'b1;
        end else begin
          rsp.status = ST_UNCHANGED;
        end
      end else begin
        rsp.status = ST_UNCHANGED;
      end
    end else if (f_found) begin
      rsp.status   = ST_INSERTED;
      rsp.next_hop = req.source_addr;
      wr_en        = 1'b1;
      wr_dest      = 1'b1;
      wr_hop       = 1'b1;
      wr_idx       = f_idx;
    end else begin
      rsp.status = ST_FULL;
    end
  end

  // table write, one entry per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        dest_r[k] <= EMPTY_ADDR;
        hop_r[k]  <= EMPTY_ADDR;
        batt_r[k] <= '0;
        rssi_r[k] <= '0;
      end
    end else if (step_en && wr_en) begin
      batt_r[wr_idx] <= req.battery_level;
      rssi_r[wr_idx] <= req.signal_strength;
      if (wr_dest) begin
        dest_r[wr_idx] <= req.dest_addr;
      end
      if (wr_hop) begin
        hop_r[wr_idx] <= req.source_addr;
      end
    end
  end

endmodule

// File: rtl/rtmu_checker.sv
// ----------------------------------------------------------------------------
// rtmu_checker
// Port-level checks for the route table metric update unit, bound to the top.
// ----------------------------------------------------------------------------
module rtmu_checker
  import rtmu_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a miss that did not insert carries the empty hop
  a_miss_hop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[3] && (out_tuser[2:0] != ST_INSERTED)
      |-> out_tdata == EMPTY_ADDR)
    else $error("miss with a stored hop");

  // metric updates only happen on a hit
  a_update_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser[2:0] == ST_REFRESHED) || (out_tuser[2:0] == ST_RAISED) ||
                   (out_tuser[2:0] == ST_REPLACED)) |-> out_tuser[3])
    else $error("update status without a hit");

endmodule

bind route_table_metric_update_unit rtmu_checker u_rtmu_checker (.*);
